[rtl/killer_history_move_order_table_macros.svh]
// Assertion helpers for the checker file.
`ifndef KILLER_HISTORY_MOVE_ORDER_TABLE_MACROS_SVH
`define KILLER_HISTORY_MOVE_ORDER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KHMOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KHMOT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/khmot_pkg.sv]
package khmot_pkg;

    // defaults for the top-level parameters
    localparam int MAX_PLY_DEF   = 64;
    localparam int MOVE_BITS_DEF = 32;

    localparam int KILLER_SLOTS = 3;
    localparam int HIST_AW      = 12;       // 64 x 64 squares
    localparam int HIST_DEPTH   = 4096;
    localparam int HIST_W       = 32;
    localparam int SCORE_W      = 20;
    localparam int HIT_W        = 2;
    localparam int OUT_W        = 24;       // score + hit, padded to bytes

    // mode codes (carried in s_tuser)
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_SCORE  = 2'd1;
    localparam logic [1:0] MODE_CUTOFF = 2'd2;

    // configuration register indexes
    localparam logic CFG_USE_KILLERS = 1'b0;
    localparam logic CFG_USE_HISTORY = 1'b1;

    // killer slot codes
    localparam logic [HIT_W-1:0] HIT_SLOT0 = 2'd0;
    localparam logic [HIT_W-1:0] HIT_SLOT1 = 2'd1;
    localparam logic [HIT_W-1:0] HIT_SLOT2 = 2'd2;
    localparam logic [HIT_W-1:0] HIT_NONE  = 2'd3;

    localparam logic [SCORE_W-1:0] SCORE_KILLER0 = 20'd900000;
    localparam logic [SCORE_W-1:0] SCORE_KILLER1 = 20'd850000;
    localparam logic [SCORE_W-1:0] SCORE_KILLER2 = 20'd800000;
    localparam logic [SCORE_W-1:0] SCORE_HISTCAP = 20'd700000;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

[rtl/killer_history_move_order_table.sv]
// Killer / history move-ordering table.
// Input channel s_*: tuser = mode (clear, score, cutoff); tdata = ply, move_code,
// from_square, to_square, is_capture, search_depth. Output channel m_*: one item
// per input item, tdata = order_score, killer_hit. Config channel cfg_*: index 0
// use_killers, index 1 use_history; cfg_ready is always high.
// Flow: an accepted item issues registered reads of the killer row and the
// history entry; then, once the output register is free, the result is
// registered on m_* and the modified row / entry is written back. s_tready
// stays low from acceptance until then, so score and cutoff items do not
// overlap. Since write-back lands before the next read there is no hazard.
// Clear items: the result comes out as above, then a sweep zeroes the history
// memory one entry per cycle (killer rows in the same pass) with s_tready low.
// Reset starts the same sweep; config writes are taken during it. If m_tready
// is low the finished item waits in the output register; the block still accepts
// one more item and holds its result (and write-back) until the output register
// frees.
module killer_history_move_order_table #(
    parameter int MAX_PLY   = khmot_pkg::MAX_PLY_DEF,
    parameter int MOVE_BITS = khmot_pkg::MOVE_BITS_DEF,
    localparam int IN_BITS  = 25 + MOVE_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    // ply[5:0], move_code[MOVE_BITS-1:0], from_square[5:0], to_square[5:0],
    // is_capture, search_depth[5:0], zero pad
    input  logic [IN_W-1:0]     s_tdata,
    // mode[1:0]
    input  logic [1:0]          s_tuser,
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    // order_score[19:0], killer_hit[1:0], zero pad
    output logic [khmot_pkg::OUT_W-1:0] m_tdata,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic                cfg_data
);

    localparam int KA_W    = (MAX_PLY > 1) ? $clog2(MAX_PLY) : 1;
    localparam int ROW_W   = khmot_pkg::KILLER_SLOTS * MOVE_BITS;
    localparam int CNT_W   = khmot_pkg::HIST_AW;
    localparam int MV_LO   = 6;
    localparam int FR_LO   = MV_LO + MOVE_BITS;
    localparam int TO_LO   = FR_LO + 6;
    localparam int CP_BIT  = TO_LO + 6;
    localparam int DP_LO   = CP_BIT + 1;
    localparam logic [8:0]       MAX_PLY_9 = 9'(MAX_PLY);
    localparam logic [CNT_W-1:0] MAX_PLY_C = CNT_W'(MAX_PLY);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(khmot_pkg::HIST_DEPTH - 1);

    // storage
    logic [ROW_W-1:0]              kmem [MAX_PLY];
    logic [khmot_pkg::HIST_W-1:0]  hmem [khmot_pkg::HIST_DEPTH];

    khmot_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              use_killers_reg, use_history_reg;

    // captured item
    logic [1:0]            mode_reg;
    logic                  row_ok_reg;
    logic [MOVE_BITS-1:0]  move_reg;
    logic [KA_W-1:0]       kaddr_reg;
    logic [CNT_W-1:0]      haddr_reg;
    logic                  cap_reg;
    logic [11:0]           dsq_reg;

    // read data
    logic [ROW_W-1:0]             krd_reg;
    logic [khmot_pkg::HIST_W-1:0] hrd_reg;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [khmot_pkg::SCORE_W-1:0] score_reg, score_next;
    logic [khmot_pkg::HIT_W-1:0]   hit_reg, hit_next;

    // memory write ports
    logic                          k_we, h_we;
    logic [KA_W-1:0]               k_wa;
    logic [ROW_W-1:0]              k_wd;
    logic [CNT_W-1:0]              h_wa;
    logic [khmot_pkg::HIST_W-1:0]  h_wd;

    // input field decode
    logic                  accept;
    logic [8:0]            ply_ext;
    logic [KA_W-1:0]       k_ra;
    logic [CNT_W-1:0]      h_ra;
    logic [5:0]            depth_in;

    // execute-stage datapath
    logic                          out_free;
    logic [MOVE_BITS-1:0]          k0, k1, k2;
    logic                          kon, eq0, eq1, eq2;
    logic [khmot_pkg::SCORE_W-1:0] hist_capped;
    logic [khmot_pkg::HIST_W:0]    hist_sum;
    logic [khmot_pkg::HIST_W-1:0]  hist_sat;
    logic                          do_cut;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign ply_ext   = {3'b000, s_tdata[5:0]};
    assign k_ra      = ply_ext[KA_W-1:0];
    assign h_ra      = {s_tdata[FR_LO +: 6], s_tdata[TO_LO +: 6]};
    assign depth_in  = s_tdata[DP_LO +: 6];

    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, hit_reg, score_reg};

    assign k0 = krd_reg[0 +: MOVE_BITS];
    assign k1 = krd_reg[MOVE_BITS +: MOVE_BITS];
    assign k2 = krd_reg[2*MOVE_BITS +: MOVE_BITS];

    // killers only count on a valid row and a real move
    assign kon = use_killers_reg && row_ok_reg && (move_reg != '0);
    assign eq0 = kon && (k0 == move_reg);
    assign eq1 = kon && (k1 == move_reg);
    assign eq2 = kon && (k2 == move_reg);

    assign hist_capped = (hrd_reg > 32'(khmot_pkg::SCORE_HISTCAP))
                       ? khmot_pkg::SCORE_HISTCAP : hrd_reg[khmot_pkg::SCORE_W-1:0];
    assign hist_sum = {1'b0, hrd_reg} + {21'd0, dsq_reg};
    assign hist_sat = hist_sum[khmot_pkg::HIST_W] ? '1 : hist_sum[khmot_pkg::HIST_W-1:0];
    assign do_cut   = (mode_reg == khmot_pkg::MODE_CUTOFF) && !cap_reg;

    // control, result and write-back
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        score_next   = score_reg;
        hit_next     = hit_reg;
        s_tready     = 1'b0;
        k_we         = 1'b0;
        k_wa         = kaddr_reg;
        k_wd         = krd_reg;
        h_we         = 1'b0;
        h_wa         = haddr_reg;
        h_wd         = hist_sat;

        unique case (state_reg)
            khmot_pkg::ST_CLEAR:
            begin
                h_we         = 1'b1;
                h_wa         = clr_cnt_reg;
                h_wd         = '0;
                k_we         = clr_cnt_reg < MAX_PLY_C;
                k_wa         = clr_cnt_reg[KA_W-1:0];
                k_wd         = '0;
                clr_cnt_next = clr_cnt_reg + CNT_W'(1);
                if (clr_cnt_reg == CNT_LAST)
                begin
                    state_next = khmot_pkg::ST_IDLE;
                end
            end
            khmot_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = khmot_pkg::ST_EXEC;
                end
            end
            khmot_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    score_next   = '0;
                    hit_next     = khmot_pkg::HIT_NONE;
                    state_next   = khmot_pkg::ST_IDLE;
                    unique case (mode_reg)
                        khmot_pkg::MODE_CLEAR:
                        begin
                            state_next   = khmot_pkg::ST_CLEAR;
                            clr_cnt_next = '0;
                        end
                        khmot_pkg::MODE_SCORE:
                        begin
                            priority if (eq0)
                            begin
                                hit_next   = khmot_pkg::HIT_SLOT0;
                                score_next = khmot_pkg::SCORE_KILLER0;
                            end
                            else if (eq1)
                            begin
                                hit_next   = khmot_pkg::HIT_SLOT1;
                                score_next = khmot_pkg::SCORE_KILLER1;
                            end
                            else if (eq2)
                            begin
                                hit_next   = khmot_pkg::HIT_SLOT2;
                                score_next = khmot_pkg::SCORE_KILLER2;
                            end
                            else if (use_history_reg)
                            begin
                                score_next = hist_capped;
                            end
                            else
                            begin
                                score_next = '0;
                            end
                        end
                        khmot_pkg::MODE_CUTOFF:
                        begin
                            if (do_cut)
                            begin
                                // slot 0 match leaves the row as it is
                                k_we = kon && !eq0;
                                k_wd = eq1 ? {k2, k0, move_reg} : {k1, k0, move_reg};
                                h_we = use_history_reg;
                            end
                        end
                        default:
                        begin
                            // unused mode: tables left unchanged
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = khmot_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= khmot_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
            use_killers_reg <= 1'b1;
            use_history_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == khmot_pkg::CFG_USE_KILLERS)
                begin
                    use_killers_reg <= cfg_data;
                end
                else
                begin
                    use_history_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        hit_reg   <= hit_next;
        if (accept)
        begin
            mode_reg   <= s_tuser;
            row_ok_reg <= ply_ext < MAX_PLY_9;
            move_reg   <= s_tdata[MV_LO +: MOVE_BITS];
            kaddr_reg  <= k_ra;
            haddr_reg  <= h_ra;
            cap_reg    <= s_tdata[CP_BIT];
            dsq_reg    <= {6'd0, depth_in} * {6'd0, depth_in};
        end
    end

    // killer rows: one row of three slots per ply
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            kmem[k_wa] <= k_wd;
        end
        if (accept)
        begin
            krd_reg <= kmem[k_ra];
        end
    end

    // history counts indexed by {from, to}
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[h_wa] <= h_wd;
        end
        if (accept)
        begin
            hrd_reg <= hmem[h_ra];
        end
    end

endmodule

[rtl/khmot_checker.sv]
`include "killer_history_move_order_table_macros.svh"

module khmot_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [khmot_pkg::OUT_W-1:0] m_tdata
);

    logic [khmot_pkg::SCORE_W-1:0] score;
    logic [khmot_pkg::HIT_W-1:0]   hit;

    assign score = m_tdata[khmot_pkg::SCORE_W-1:0];
    assign hit   = m_tdata[khmot_pkg::SCORE_W +: khmot_pkg::HIT_W];

    `KHMOT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `KHMOT_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item accepted back to back")
    `KHMOT_ASSERT_NOW(a_killer_score, m_tvalid && (hit == khmot_pkg::HIT_SLOT0), score == khmot_pkg::SCORE_KILLER0, "slot 0 hit with wrong score")
    `KHMOT_ASSERT_NOW(a_hist_cap, m_tvalid && (hit == khmot_pkg::HIT_NONE), score <= khmot_pkg::SCORE_HISTCAP, "history score over cap")

endmodule

bind killer_history_move_order_table khmot_checker u_khmot_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_killer_history_move_order_table.sv]
module tb_killer_history_move_order_table;

    import khmot_pkg::*;

    // Item fields, first field lowest once packed into s_tdata.
    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  ply;
        logic [31:0] move_code;
        logic [5:0]  from_sq;
        logic [5:0]  to_sq;
        logic        capture;
        logic [5:0]  depth;
    } move_req_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [HIT_W-1:0]   hit;
    } order_res_t;

    // One directed row: the item, and a hand-typed result where it is obvious.
    typedef struct packed {
        move_req_t  req;
        logic       typed;
        order_res_t want;
    } step_row_t;

    localparam int         IN_W        = 64;       // 57 bits of fields, padded to bytes
    localparam logic [1:0] MODE_UNUSED = 2'd3;     // spare mode code, must be a no-op
    localparam int         PLY_ROWS    = MAX_PLY_DEF;
    localparam int         SETTLE      = 8;        // result + write-back, with margin
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         BURST_LEN   = 200;

    // Distinct move words: every bit high and low somewhere.
    localparam logic [31:0] MV_A = 32'hFFFF_FFFF;
    localparam logic [31:0] MV_B = 32'h8000_0001;
    localparam logic [31:0] MV_C = 32'h5A5A_A5A5;
    localparam logic [31:0] MV_D = 32'h0000_7E00;
    localparam logic [31:0] MV_NONE = 32'h0000_0000;

    localparam int N_DIR = 23;

    // Directed table. Typed rows: empty tables after reset, slot order
    // right after known inserts, the spare mode and clear. Others go
    // through the predictor.
    localparam step_row_t DIR_ROWS [N_DIR] = '{
        // empty tables: no killer, zero history
        '{'{MODE_SCORE,  6'd0,  MV_B,    6'd0,  6'd0,  1'b0, 6'd0},  1'b1, '{20'd0, HIT_NONE}},
        // spare mode with every field at its top value
        '{'{MODE_UNUSED, 6'd63, MV_A,    6'd63, 6'd63, 1'b1, 6'd63}, 1'b1, '{20'd0, HIT_NONE}},
        '{'{MODE_CUTOFF, 6'd0,  MV_A,    6'd63, 6'd63, 1'b0, 6'd63}, 1'b1, '{20'd0, HIT_NONE}},
        // capture flag ignored when scoring
        '{'{MODE_SCORE,  6'd0,  MV_A,    6'd63, 6'd63, 1'b1, 6'd0},  1'b1,
            '{SCORE_KILLER0, HIT_SLOT0}},
        '{'{MODE_CUTOFF, 6'd0,  MV_B,    6'd1,  6'd2,  1'b0, 6'd1},  1'b1, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd0,  MV_B,    6'd0,  6'd0,  1'b0, 6'd0},  1'b1,
            '{SCORE_KILLER0, HIT_SLOT0}},
        '{'{MODE_SCORE,  6'd0,  MV_A,    6'd0,  6'd0,  1'b0, 6'd0},  1'b1,
            '{SCORE_KILLER1, HIT_SLOT1}},
        '{'{MODE_CUTOFF, 6'd0,  MV_C,    6'd0,  6'd0,  1'b0, 6'd0},  1'b1, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd0,  MV_A,    6'd0,  6'd0,  1'b0, 6'd0},  1'b1,
            '{SCORE_KILLER2, HIT_SLOT2}},
        // slot 2 -> front, slot 2 -> front, slot 1 swap, already first
        '{'{MODE_CUTOFF, 6'd0,  MV_A,    6'd0,  6'd0,  1'b0, 6'd2},  1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_CUTOFF, 6'd0,  MV_B,    6'd0,  6'd0,  1'b0, 6'd2},  1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_CUTOFF, 6'd0,  MV_A,    6'd0,  6'd0,  1'b0, 6'd2},  1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_CUTOFF, 6'd0,  MV_A,    6'd0,  6'd0,  1'b0, 6'd2},  1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd0,  MV_C,    6'd0,  6'd0,  1'b0, 6'd0},  1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd0,  MV_B,    6'd0,  6'd0,  1'b0, 6'd0},  1'b0, '{20'd0, HIT_NONE}},
        // cutoff by a capture leaves both stores alone
        '{'{MODE_CUTOFF, 6'd63, MV_D,    6'd63, 6'd63, 1'b1, 6'd63}, 1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd63, MV_D,    6'd63, 6'd63, 1'b0, 6'd0},  1'b0, '{20'd0, HIT_NONE}},
        // no-move word: history only, and never matches an empty slot
        '{'{MODE_CUTOFF, 6'd63, MV_NONE, 6'd5,  6'd6,  1'b0, 6'd10}, 1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd63, MV_NONE, 6'd5,  6'd6,  1'b0, 6'd0},  1'b0, '{20'd0, HIT_NONE}},
        // same move, other ply: history only
        '{'{MODE_SCORE,  6'd1,  MV_A,    6'd63, 6'd63, 1'b0, 6'd0},  1'b0, '{20'd0, HIT_NONE}},
        '{'{MODE_CLEAR,  6'd0,  MV_NONE, 6'd0,  6'd0,  1'b0, 6'd0},  1'b1, '{20'd0, HIT_NONE}},
        '{'{MODE_SCORE,  6'd0,  MV_A,    6'd63, 6'd63, 1'b0, 6'd0},  1'b1, '{20'd0, HIT_NONE}},
        '{'{MODE_UNUSED, 6'd0,  MV_NONE, 6'd0,  6'd0,  1'b0, 6'd0},  1'b1, '{20'd0, HIT_NONE}}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // ply, move_code, from_square, to_square, is_capture, search_depth, zero pad
    logic [IN_W-1:0]     s_tdata;
    // mode
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // order_score, killer_hit, zero pad
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic                cfg_data;

    // Predictor state: own copy of both stores and both enables.
    logic [31:0] killer_rows [PLY_ROWS][KILLER_SLOTS];
    logic [31:0] hist_counts [HIST_DEPTH];
    logic        pol_killers;
    logic        pol_history;

    order_res_t  pending_scores [$];   // expected results, oldest first
    order_res_t  head_score;
    logic [31:0] move_pool [6];        // small set so killers actually hit
    logic [5:0]  hot_from;
    logic [5:0]  hot_to;
    bit          idle_on;              // gaps and stalls allowed in this stretch
    int          stall_left;
    int          error_count;
    int          cycle_count;

    killer_history_move_order_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic wipe_tables();
        for (int p = 0; p < PLY_ROWS; p++)
            for (int s = 0; s < KILLER_SLOTS; s++)
                killer_rows[p][s] = '0;
        for (int h = 0; h < HIST_DEPTH; h++)
            hist_counts[h] = '0;
    endtask

    // Ordering score for one item; updates the stores like the block does.
    task automatic order_predict(input move_req_t r, output order_res_t res);
        logic [11:0] hidx;
        logic [11:0] dsq;
        logic [32:0] sum;
        logic [31:0] cnt;
        bit          row_ok;
        bit          found;
        hidx   = {r.from_sq, r.to_sq};
        row_ok = (int'(r.ply) < MAX_PLY_DEF);
        found  = 1'b0;
        res.score = '0;
        res.hit   = HIT_NONE;
        case (r.mode)
            MODE_CLEAR: wipe_tables();
            MODE_SCORE:
            begin
                // zero word never matches: empty slots hold zero
                if (pol_killers && row_ok && r.move_code != '0)
                begin
                    for (int s = 0; s < KILLER_SLOTS; s++)
                    begin
                        if (!found && killer_rows[r.ply][s] == r.move_code)
                        begin
                            found   = 1'b1;
                            res.hit = HIT_W'(s);
                        end
                    end
                end
                case (res.hit)
                    HIT_SLOT0: res.score = SCORE_KILLER0;
                    HIT_SLOT1: res.score = SCORE_KILLER1;
                    HIT_SLOT2: res.score = SCORE_KILLER2;
                    default:
                    begin
                        if (pol_history)
                        begin
                            cnt = hist_counts[hidx];
                            res.score = (cnt > 32'(SCORE_HISTCAP)) ? SCORE_HISTCAP
                                                                   : cnt[SCORE_W-1:0];
                        end
                    end
                endcase
            end
            MODE_CUTOFF:
            begin
                if (!r.capture)
                begin
                    if (pol_killers && row_ok && r.move_code != '0)
                    begin
                        if (killer_rows[r.ply][0] == r.move_code)
                        begin
                            // already first, nothing moves
                        end
                        else if (killer_rows[r.ply][1] == r.move_code)
                        begin
                            killer_rows[r.ply][1] = killer_rows[r.ply][0];
                            killer_rows[r.ply][0] = r.move_code;
                        end
                        else
                        begin
                            killer_rows[r.ply][2] = killer_rows[r.ply][1];
                            killer_rows[r.ply][1] = killer_rows[r.ply][0];
                            killer_rows[r.ply][0] = r.move_code;
                        end
                    end
                    if (pol_history)
                    begin
                        dsq = {6'd0, r.depth} * {6'd0, r.depth};
                        sum = {1'b0, hist_counts[hidx]} + {21'd0, dsq};
                        hist_counts[hidx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                end
            end
            default: ;  // spare mode: no change
        endcase
    endtask

    // Mostly short idles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one item at the falling edge and hold it until accepted.
    task automatic send_item(input move_req_t r, input bit typed, input order_res_t typed_res);
        int         gap;
        order_res_t res;
        gap = (idle_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {7'd0, r.depth, r.capture, r.to_sq, r.from_sq, r.move_code, r.ply};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        order_predict(r, res);
        pending_scores.insert(pending_scores.size(), typed ? typed_res : res);
    endtask

    // Stop sending and wait until every result is back and the block is quiet.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write both enables back to back; valid held high across the pair.
    task automatic set_policy(input logic killers_en, input logic history_en);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_USE_KILLERS;
        cfg_data  <= killers_en;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pol_killers = killers_en;
        @(negedge clk);
        cfg_index <= CFG_USE_HISTORY;
        cfg_data  <= history_en;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pol_history = history_en;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic move_req_t random_req();
        move_req_t r;
        int        pick;
        pick = $urandom_range(0, 999);
        if (pick < 8)
            r.mode = MODE_CLEAR;            // rare: each costs a full sweep
        else if (pick < 30)
            r.mode = MODE_UNUSED;
        else if (pick < 550)
            r.mode = MODE_SCORE;
        else
            r.mode = MODE_CUTOFF;
        r.ply       = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 2)) : 6'($urandom);
        r.move_code = ($urandom_range(0, 9) < 8) ? move_pool[$urandom_range(0, 5)] : $urandom;
        r.from_sq   = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 3)) : 6'($urandom);
        r.to_sq     = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 3)) : 6'($urandom);
        r.capture   = ($urandom_range(0, 3) == 0);
        r.depth     = 6'($urandom);
        return r;
    endfunction

    task automatic random_phase(input logic killers_en, input logic history_en, input int count);
        set_policy(killers_en, history_en);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 9) >= 3);
            send_item(random_req(), 1'b0, '0);
        end
        drain_results();
    endtask

    // Result side: random back-pressure, changed at the falling edge.
    initial
    begin
        m_tready   = 1'b1;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 20)
                stall_left = idle_len();
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Compare each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scores.size() == 0)
                report_mismatch($sformatf("result with none pending: tdata=%h", m_tdata));
            else
            begin
                head_score = pending_scores.pop_front();
                if (m_tdata[SCORE_W-1:0] !== head_score.score)
                    report_mismatch($sformatf("order_score %0d, expected %0d",
                                              m_tdata[SCORE_W-1:0], head_score.score));
                if (m_tdata[SCORE_W +: HIT_W] !== head_score.hit)
                    report_mismatch($sformatf("killer_hit %0d, expected %0d",
                                              m_tdata[SCORE_W +: HIT_W], head_score.hit));
            end
        end
    end

    // Watchdog; covers the clearing sweeps after reset and after each clear.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        move_req_t hot;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_CLEAR;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_USE_KILLERS;
        cfg_data    = 1'b0;
        error_count = 0;
        idle_on     = 1'b1;
        pol_killers = 1'b1;
        pol_history = 1'b1;
        wipe_tables();
        move_pool[0] = MV_NONE;
        for (int i = 1; i < 6; i++)
            move_pool[i] = $urandom;
        hot_from = 6'($urandom);
        hot_to   = 6'($urandom);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, default enables from reset
        for (int i = 0; i < N_DIR; i++)
            send_item(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        drain_results();

        // random phases over every enable combination
        random_phase(1'b1, 1'b1, 100);

        // one history entry pumped past the score cap, with scores mixed in
        set_policy(1'b1, 1'b1);
        for (int i = 0; i < BURST_LEN; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 9) >= 3);
            hot = random_req();
            hot.from_sq = hot_from;
            hot.to_sq   = hot_to;
            if (i % 10 == 9)
            begin
                hot.mode      = MODE_SCORE;
                hot.move_code = $urandom;
            end
            else
            begin
                hot.mode    = MODE_CUTOFF;
                hot.capture = 1'b0;
                hot.depth   = 6'd63;
            end
            send_item(hot, 1'b0, '0);
        end
        drain_results();

        random_phase(1'b0, 1'b1, 80);
        random_phase(1'b1, 1'b0, 80);
        random_phase(1'b0, 1'b0, 60);
        random_phase(1'b1, 1'b1, 80);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/khmot_pkg.sv
rtl/killer_history_move_order_table.sv
rtl/khmot_checker.sv
dv/tb_killer_history_move_order_table.sv
